/* rtl/core/pmf_pkg.sv */
// Shared types, character constants and divider tables for the position message formatter.
`timescale 1ns / 1ps

package pmf_pkg;

    localparam int POS_W = 17;
    localparam int BYTE_W = 8;
    localparam int DIGIT_W = 4;
    localparam int QUOT_W = 4;
    localparam int RECIP_W = 17;
    localparam int PROD_W = POS_W + RECIP_W;
    localparam int SHIFT_W = 5;
    localparam int DIVISOR_W = 14;
    localparam int STEP_W = 3;
    localparam int PAYLOAD_W = 16;

    localparam logic [BYTE_W-1:0] HDR_BYTE = 8'hAA;
    localparam logic [BYTE_W-1:0] CH_P = 8'h50;
    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

    // Last step of the digit sequencer (subtract for the tens divisor).
    localparam logic [STEP_W-1:0] STEP_LAST = 3'd6;

    // Byte positions within a message.
    localparam logic [STEP_W-1:0] BIN_LAST_IDX = 3'd3;
    localparam logic [STEP_W-1:0] ASC_LAST_IDX = 3'd7;

    typedef enum logic [1:0] {
        DIV_10000 = 2'd0,
        DIV_1000  = 2'd1,
        DIV_100   = 2'd2,
        DIV_10    = 2'd3
    } pmf_div_sel_t;

    typedef enum logic [1:0] {
        FRONT_IDLE = 2'd0,
        FRONT_CALC = 2'd1,
        FRONT_PUSH = 2'd2
    } pmf_front_state_t;

    // One queued message: binary mode carries position bits 15..0, ASCII mode
    // carries four BCD digits, thousands in the top nibble.
    typedef struct packed {
        logic                 binary;
        logic [PAYLOAD_W-1:0] data;
    } pmf_entry_t;

    // Queue head as seen by the back end.
    typedef struct packed {
        logic       valid;
        pmf_entry_t entry;
    } pmf_head_t;

    // Reciprocals are rounded up; each one is exact over the range its
    // dividend can take.
    function automatic logic [RECIP_W-1:0] pmf_recip(input pmf_div_sel_t sel);
        logic [RECIP_W-1:0] r;
        unique case (sel)
            DIV_10000: r = 17'd107375;
            DIV_1000:  r = 17'd16778;
            DIV_100:   r = 17'd656;
            DIV_10:    r = 17'd103;
            default:   r = '0;
        endcase
        return r;
    endfunction

    function automatic logic [SHIFT_W-1:0] pmf_shift(input pmf_div_sel_t sel);
        logic [SHIFT_W-1:0] s;
        unique case (sel)
            DIV_10000: s = 5'd30;
            DIV_1000:  s = 5'd24;
            DIV_100:   s = 5'd16;
            DIV_10:    s = 5'd10;
            default:   s = '0;
        endcase
        return s;
    endfunction

    function automatic logic [DIVISOR_W-1:0] pmf_divisor(input pmf_div_sel_t sel);
        logic [DIVISOR_W-1:0] d;
        unique case (sel)
            DIV_10000: d = 14'd10000;
            DIV_1000:  d = 14'd1000;
            DIV_100:   d = 14'd100;
            DIV_10:    d = 14'd10;
            default:   d = '0;
        endcase
        return d;
    endfunction

endpackage

/* rtl/core/pmf_front.sv */
// Front end: accepts positions and turns ASCII-mode positions into four decimal digits.
`timescale 1ns / 1ps

module pmf_front import pmf_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [POS_W-1:0] position,
    input  logic             out_format,
    output logic             push_valid,
    input  logic             push_ready,
    output pmf_entry_t       push_entry
);

    pmf_front_state_t    state_reg, state_next;
    logic [STEP_W-1:0]   step_reg;
    logic [QUOT_W-1:0]   quot_reg;
    logic [POS_W-1:0]    rem_reg;
    logic [3*DIGIT_W-1:0] dig_reg;
    logic                bin_reg;

    logic                accept;
    logic [POS_W-1:0]    mul_src;
    pmf_div_sel_t        mul_sel;
    pmf_div_sel_t        sub_sel;
    logic [PROD_W-1:0]   product;
    logic [PROD_W-1:0]   prod_shifted;
    logic [QUOT_W-1:0]   quot_next;
    logic [POS_W:0]      sub_res;

    assign accept = s_tvalid && s_tready;

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FRONT_IDLE: begin
                if (s_tvalid) begin
                    state_next = out_format ? FRONT_PUSH : FRONT_CALC;
                end
            end
            FRONT_CALC: begin
                if (step_reg == STEP_LAST) begin
                    state_next = FRONT_PUSH;
                end
            end
            FRONT_PUSH: begin
                if (push_ready) begin
                    if (s_tvalid) begin
                        state_next = out_format ? FRONT_PUSH : FRONT_CALC;
                    end else begin
                        state_next = FRONT_IDLE;
                    end
                end
            end
            default: state_next = FRONT_IDLE;
        endcase
    end

    // Outputs of the state machine.
    always_comb begin
        s_tready   = 1'b0;
        push_valid = 1'b0;
        unique case (state_reg)
            FRONT_IDLE: s_tready = 1'b1;
            FRONT_CALC: s_tready = 1'b0;
            FRONT_PUSH: begin
                s_tready   = push_ready;
                push_valid = 1'b1;
            end
            default: s_tready = 1'b0;
        endcase
    end

    // Odd steps multiply by the next reciprocal, even steps subtract the
    // quotient times the current divisor.
    always_comb begin
        mul_src      = accept ? position : rem_reg;
        mul_sel      = accept ? DIV_10000 : pmf_div_sel_t'(step_reg[2:1] + 2'd1);
        sub_sel      = pmf_div_sel_t'(step_reg[2:1]);
        product      = PROD_W'(mul_src) * PROD_W'(pmf_recip(mul_sel));
        prod_shifted = product >> pmf_shift(mul_sel);
        quot_next    = prod_shifted[QUOT_W-1:0];
        sub_res      = {1'b0, rem_reg}
                       - ((POS_W+1)'(quot_reg) * (POS_W+1)'(pmf_divisor(sub_sel)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FRONT_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                step_reg <= '0;
            end else if (state_reg == FRONT_CALC) begin
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rem_reg  <= position;
            quot_reg <= quot_next;
            bin_reg  <= out_format;
        end else if (state_reg == FRONT_CALC) begin
            if (!step_reg[0]) begin
                rem_reg <= sub_res[POS_W-1:0];
                if (step_reg != '0) begin
                    dig_reg <= {dig_reg[2*DIGIT_W-1:0], quot_reg};
                end
            end else begin
                quot_reg <= quot_next;
            end
        end
    end

    always_comb begin
        push_entry.binary = bin_reg;
        push_entry.data   = bin_reg ? rem_reg[PAYLOAD_W-1:0]
                                    : {dig_reg, rem_reg[DIGIT_W-1:0]};
    end

endmodule

/* rtl/core/pmf_fifo.sv */
// Short queue of decoded messages between the front and back ends.
`timescale 1ns / 1ps

module pmf_fifo import pmf_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push_valid,
    output logic       push_ready,
    input  pmf_entry_t push_entry,
    input  logic       pop,
    output pmf_head_t  head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    pmf_entry_t      slots_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg;
    logic [AW-1:0]   rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.entry = slots_reg[rd_ptr_reg];

    function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* rtl/core/pmf_back.sv */
// Back end: walks the queued message byte by byte into the output register.
`timescale 1ns / 1ps

module pmf_back import pmf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  pmf_head_t         head,
    output logic              pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,
    output logic              m_tlast
);

    logic [STEP_W-1:0] idx_reg;
    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              last_reg;

    logic              load;
    logic              is_last;
    logic [BYTE_W-1:0] byte_next;
    logic [DIGIT_W-1:0] digit;

    assign load    = head.valid && (!valid_reg || m_tready);
    assign is_last = head.entry.binary ? (idx_reg == BIN_LAST_IDX)
                                       : (idx_reg == ASC_LAST_IDX);
    assign pop     = load && is_last;

    // Digits sit thousands first in the payload; byte 2 takes the top nibble.
    always_comb begin
        unique case (idx_reg)
            3'd2:    digit = head.entry.data[15:12];
            3'd3:    digit = head.entry.data[11:8];
            3'd4:    digit = head.entry.data[7:4];
            default: digit = head.entry.data[3:0];
        endcase
    end

    always_comb begin
        if (head.entry.binary) begin
            unique case (idx_reg)
                3'd2:    byte_next = head.entry.data[15:8];
                3'd3:    byte_next = head.entry.data[7:0];
                default: byte_next = HDR_BYTE;
            endcase
        end else begin
            unique case (idx_reg)
                3'd0:    byte_next = CH_P;
                3'd1:    byte_next = CH_COLON;
                3'd6:    byte_next = CH_CR;
                3'd7:    byte_next = CH_LF;
                default: byte_next = CH_ZERO + BYTE_W'(digit);
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                idx_reg   <= is_last ? '0 : idx_reg + 3'd1;
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= byte_next;
            last_reg <= is_last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tlast  = last_reg;

endmodule

/* rtl/core/position_message_formatter.sv */
// Top level of the position message formatter: config register, front end, queue, back end.
// Throughput: one word per cycle on the output while m_tready is high and a message is queued;
// an ASCII position occupies the front end for seven multiply/subtract steps on its one
// reciprocal multiplier and then the hand-off, a binary position only for the hand-off, so the
// output byte rate sets the pace.
// Reset: aresetn is synchronous and active low; it empties the queue, idles both ends and
// returns the format register to ASCII.
`timescale 1ns / 1ps

module position_message_formatter import pmf_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input stream. s_tdata: [16:0] position, [23:17] zero.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,
    // Output stream. m_tdata: [7:0] out_byte. m_tlast carries last_byte.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic        m_tlast,
    // Register port. Register 0 (byte address 0): bit 0 out_format.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // The format register selects ASCII text (0) or binary with header (1).
    // It must only be written while the block is idle (the user's duty; the block itself does
    // not enforce it), so the front end samples it directly when a position is accepted.
    logic       out_format_reg;
    logic       cfg_write;

    logic       push_valid;
    logic       push_ready;
    pmf_entry_t push_entry;
    logic       pop;
    pmf_head_t  head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? {31'd0, out_format_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_format_reg <= 1'b0;
        end else if (cfg_write) begin
            out_format_reg <= pwdata[0];
        end
    end

    // In ASCII mode the front end reduces the position modulo 10000 and splits
    // it into decimal digits, one reciprocal multiply or one subtract per cycle.
    pmf_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .position   (s_tdata[POS_W-1:0]),
        .out_format (out_format_reg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    // The queue lets the front end start the next position while the back
    // end is still sending the previous message.
    pmf_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head)
    );

    // The back end sends the message at the queue head one byte per cycle while
    // m_tready is high, through its output register, and pops the entry with the final byte.
    pmf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* rtl/core/pmf_checker.sv */
// Port-level checks on the position message formatter, bound to the top level.
`timescale 1ns / 1ps

module pmf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        pready
);

    // A stalled output word holds its value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // Reset leaves no word on the output.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid right after reset");

    // A message that follows straight on from the last one opens with its header byte.
    a_msg_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=>
            !m_tvalid || m_tdata == 8'h50 || m_tdata == 8'hAA)
        else $error("message does not start with a header byte");

    // The register port never stalls.
    a_apb_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        psel && !penable |=> pready)
        else $error("register port not ready in access phase");

endmodule

bind position_message_formatter pmf_checker u_pmf_checker (.*);

/* sim/testbench.sv */
// Testbench for the position message formatter: a scoreboard, stream drivers and register access.
`timescale 1ns / 1ps

// Works out the bytes that each accepted position must turn into, and checks
// every word that leaves the block against the oldest byte still due.
class message_scoreboard;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } msg_byte_t;

    msg_byte_t due_bytes[$];
    int        errors;
    int        words_seen;

    function void push_byte(input logic [7:0] data, input logic last);
        msg_byte_t b;
        b.data = data;
        b.last = last;
        due_bytes.push_back(b);
    endfunction

    // Expands one position into its message under the given format.
    function void note_position(input logic [16:0] pos, input bit binary);
        int unsigned low;
        if (binary) begin
            push_byte(pmf_pkg::HDR_BYTE, 1'b0);
            push_byte(pmf_pkg::HDR_BYTE, 1'b0);
            push_byte(pos[15:8], 1'b0);
            push_byte(pos[7:0], 1'b1);
        end else begin
            low = int'(pos) % 10000;
            push_byte(pmf_pkg::CH_P, 1'b0);
            push_byte(pmf_pkg::CH_COLON, 1'b0);
            push_byte(pmf_pkg::CH_ZERO + 8'(low / 1000), 1'b0);
            push_byte(pmf_pkg::CH_ZERO + 8'((low % 1000) / 100), 1'b0);
            push_byte(pmf_pkg::CH_ZERO + 8'((low % 100) / 10), 1'b0);
            push_byte(pmf_pkg::CH_ZERO + 8'(low % 10), 1'b0);
            push_byte(pmf_pkg::CH_CR, 1'b0);
            push_byte(pmf_pkg::CH_LF, 1'b1);
        end
    endfunction

    function void check_word(input logic [7:0] data, input logic last);
        msg_byte_t b;
        if (due_bytes.size() == 0) begin
            $display("%0t: unexpected word: expected none, got data %02h last %0b",
                     $time, data, last);
            errors++;
            return;
        end
        b = due_bytes.pop_front();
        if (data !== b.data) begin
            $display("%0t: word %0d data: expected %02h, got %02h",
                     $time, words_seen, b.data, data);
            errors++;
        end
        if (last !== b.last) begin
            $display("%0t: word %0d last: expected %0b, got %0b",
                     $time, words_seen, b.last, last);
            errors++;
        end
        words_seen++;
    endfunction

    function int pending();
        return due_bytes.size();
    endfunction

endclass

module testbench;
    import pmf_pkg::*;

    // Message formats as held in bit 0 of the format register.
    typedef enum bit {
        FMT_ASCII  = 1'b0,
        FMT_BINARY = 1'b1
    } msg_format_t;

    // Byte address of the format register, and one address that maps to no register.
    localparam logic [2:0] ADDR_OUT_FORMAT = 3'd0;
    localparam logic [2:0] ADDR_UNMAPPED = 3'd4;

    // The worst case per position is a sender gap plus eight words, each behind a full
    // receiver stall; the limit leaves a wide margin.
    localparam int CYCLE_LIMIT = 400000;
    // This settles the block before a register write.
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD = 150;
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 48;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [16:0] position, [23:17] zero
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] out_byte
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    message_scoreboard sb;

    // Format that the block should be using; changes only when it is idle.
    msg_format_t fmt_model;

    // Idling controls. When an idle flag is clear that side runs flat out.
    bit tx_idle;
    bit rx_idle;
    int stall_left;
    int hold_cycles;
    int cycle_count;

    position_message_formatter dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // The run ends here if the block stops making progress.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Receiver side. m_tready is decided once per cycle at the falling edge.
    // A long hold, once requested, is counted down here while the sender keeps
    // offering positions, so the queue fills and s_tready drops.
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_tready <= 1'b0;
                hold_cycles--;
            end else if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Every accepted word is checked, and the stall before the next word drawn.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_word(m_tdata, m_tlast);
            stall_left = rx_idle ? int'($urandom_range(0, 8)) : 0;
        end
    end

    // Offers one position after an optional gap and returns once it is taken.
    // tvalid stays high between back-to-back words so it is never dropped and
    // raised within one time step.
    task automatic send_position(input logic [16:0] pos);
        int gap;
        gap = tx_idle ? int'($urandom_range(0, 8)) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {7'b0, pos};
        do @(posedge aclk); while (!s_tready);
        sb.note_position(pos, fmt_model == FMT_BINARY);
    endtask

    // Drops tvalid and waits until every due byte has come out, then lets the
    // block settle so a register write cannot land mid-message.
    task automatic drain_block();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [2:0] addr, input logic [31:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        // Only bit 0 of register 0 exists; everything else is dropped.
        if (addr == ADDR_OUT_FORMAT)
            fmt_model = msg_format_t'(value[0]);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic check_format_reg();
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= ADDR_OUT_FORMAT;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {31'b0, fmt_model}) begin
            $display("%0t: format register read: expected %08h, got %08h",
                     $time, {31'b0, fmt_model}, prdata);
            sb.errors++;
        end
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [16:0] pick_position();
        int unsigned r;
        r = $urandom_range(0, 9);
        // Mostly the full range; some values near the decimal wrap and the top.
        if (r == 0)
            return 17'(131071 - $urandom_range(0, 3));
        else if (r == 1)
            return 17'(10000 * $urandom_range(0, 13) + $urandom_range(0, 2) - 1);
        else if (r == 2)
            return 17'($urandom_range(0, 9999));
        return 17'($urandom_range(0, 131071));
    endfunction

    initial begin
        logic [31:0] wval;
        sb = new();
        fmt_model = FMT_ASCII;
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        stall_left = 0;
        hold_cycles = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. After reset the block must format as ASCII text.
        check_format_reg();
        send_position(17'd0);
        send_position(17'd9999);
        send_position(17'd10000);       // first value past four digits
        send_position(17'd131071);      // top of the range, low digits 1071
        send_position(17'd12345);
        send_position(17'd99999);
        send_position(17'd65536);
        send_position(17'd70001);
        drain_block();

        // Upper register bits are ignored: this keeps the ASCII format.
        reg_write(ADDR_OUT_FORMAT, 32'hFFFF_FFFE);
        check_format_reg();
        send_position(17'd4321);
        drain_block();

        // A write to an address with no register behind it must change nothing.
        reg_write(ADDR_UNMAPPED, 32'hFFFF_FFFF);
        check_format_reg();
        send_position(17'd5678);
        drain_block();

        // Binary format, including bit 16 set, which must not show up.
        reg_write(ADDR_OUT_FORMAT, 32'h0000_0001);
        check_format_reg();
        send_position(17'h00000);
        send_position(17'h1FFFF);
        send_position(17'h10000);
        send_position(17'h0FFFF);
        send_position(17'h000FF);
        send_position(17'h0FF00);
        send_position(17'h05555);
        send_position(17'h1AAAA);
        drain_block();

        // Random phases. Each one starts from an idle block with a format, mostly alternating,
        // written under random upper bits, and a mix of idling on each side set by the phase number.
        for (int p = 0; p < PHASES; p++) begin
            wval = $urandom();
            wval[0] = (p % 2 == 0) ? FMT_ASCII : FMT_BINARY;
            if ($urandom_range(0, 3) == 0)
                wval[0] = $urandom_range(0, 1);
            reg_write(ADDR_OUT_FORMAT, wval);
            if (p == 3)
                reg_write(ADDR_UNMAPPED, ~wval);
            check_format_reg();
            tx_idle = (p % 4) inside {1, 3};
            rx_idle = (p % 4) inside {2, 3};
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // Once per run the receiver stops for a long stretch while
                // positions keep coming.
                if (p == 2 && i == 6)
                    hold_cycles = LONG_HOLD;
                // Halfway through some phases, switch both sides to random idling.
                if (i == PHASE_ITEMS / 2 && p >= 4) begin
                    tx_idle = 1'b1;
                    rx_idle = 1'b1;
                end
                send_position(pick_position());
            end
            drain_block();
        end

        // Everything sent has been matched; give the block time to show any
        // stray word before the verdict.
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.pending() != 0) begin
            $display("%0t: %0d expected words never arrived", $time, sb.pending());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/pmf_pkg.sv
rtl/core/pmf_front.sv
rtl/core/pmf_fifo.sv
rtl/core/pmf_back.sv
rtl/core/position_message_formatter.sv
rtl/core/pmf_checker.sv
sim/testbench.sv
